### rtl/core/lramt_pkg.sv
// ----------------------------------------------------------------------------
// lramt_pkg
// Shared types, constants and saturating arithmetic for the lazy range-add /
// range-max tree.
// ----------------------------------------------------------------------------
package lramt_pkg;

    localparam int DW      = 40;
    localparam int DELTA_W = 16;

    localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_CHILD_A,
        ST_CHILD_B,
        ST_NODE,
        ST_UP
    } walk_state_t;

    function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1])
            return s[DW] ? VAL_MIN : VAL_MAX;
        else
            return s[DW-1:0];
    endfunction

endpackage

### rtl/core/lazy_range_add_max_tree_unit.sv
// ----------------------------------------------------------------------------
// lazy_range_add_max_tree_unit
// Lazy segment tree, range add and range maximum; node maxima and pending
// adds live in two RAMs walked by a depth-first sequencer.
// ----------------------------------------------------------------------------
// Each node visited passes through the read, evaluate and node states, with
//   child A and B states per child when a pending amount moves down, and the
//   up state on the way back. done strobes as busy falls, or in the cycle
//   after start for an empty range. One transaction at a time.
// Reset: a clearing pass zeroes all 2*SPAN-1 entries (2047 at 1024 leaves)
//   of both RAMs; busy stays high until it ends. Results cannot be stalled.
module lazy_range_add_max_tree_unit
    import lramt_pkg::*;
#(
    parameter int LEAVES = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        opcode,
    input  logic [$clog2(LEAVES+1)-1:0] range_low,
    input  logic [$clog2(LEAVES+1)-1:0] range_high,
    input  logic signed [DELTA_W-1:0]   delta,
    output logic                        done,
    output logic signed [DW-1:0]        range_max
);

    localparam int LOG   = $clog2(LEAVES);
    localparam int NODES = 2 * (1 << LOG) - 1;
    localparam int AW    = LOG + 1;

    logic                 max_we, pend_we;
    logic [AW-1:0]        max_waddr, max_raddr, pend_waddr, pend_raddr;
    logic signed [DW-1:0] max_wdata, max_rdata, pend_wdata, pend_rdata;

    lramt_walk #(
        .LEAVES (LEAVES)
    ) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .range_low  (range_low),
        .range_high (range_high),
        .delta      (delta),
        .done       (done),
        .range_max  (range_max),
        .max_we     (max_we),
        .max_waddr  (max_waddr),
        .max_wdata  (max_wdata),
        .max_raddr  (max_raddr),
        .max_rdata  (max_rdata),
        .pend_we    (pend_we),
        .pend_waddr (pend_waddr),
        .pend_wdata (pend_wdata),
        .pend_raddr (pend_raddr),
        .pend_rdata (pend_rdata)
    );

    lramt_ram #(
        .WIDTH (DW),
        .DEPTH (NODES)
    ) u_max_ram (
        .clk   (clk),
        .we    (max_we),
        .waddr (max_waddr),
        .wdata (max_wdata),
        .raddr (max_raddr),
        .rdata (max_rdata)
    );

    lramt_ram #(
        .WIDTH (DW),
        .DEPTH (NODES)
    ) u_pend_ram (
        .clk   (clk),
        .we    (pend_we),
        .waddr (pend_waddr),
        .wdata (pend_wdata),
        .raddr (pend_raddr),
        .rdata (pend_rdata)
    );

endmodule

### rtl/core/lramt_ram.sv
// ----------------------------------------------------------------------------
// lramt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lramt_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 2047
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/lramt_walk.sv
// ----------------------------------------------------------------------------
// lramt_walk
// Tree walker: clears the node memories after reset, then walks the tree
// depth first per transaction, pushing pending adds down and rebuilding
// maxima on the way back up after an add.
// ----------------------------------------------------------------------------
module lramt_walk
    import lramt_pkg::*;
#(
    parameter int LEAVES = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                opcode,
    input  logic [$clog2(LEAVES+1)-1:0]         range_low,
    input  logic [$clog2(LEAVES+1)-1:0]         range_high,
    input  logic signed [DELTA_W-1:0]           delta,
    output logic                                done,
    output logic signed [DW-1:0]                range_max,
    output logic                                max_we,
    output logic [$clog2(LEAVES)+0:0]           max_waddr,
    output logic signed [DW-1:0]                max_wdata,
    output logic [$clog2(LEAVES)+0:0]           max_raddr,
    input  logic signed [DW-1:0]                max_rdata,
    output logic                                pend_we,
    output logic [$clog2(LEAVES)+0:0]           pend_waddr,
    output logic signed [DW-1:0]                pend_wdata,
    output logic [$clog2(LEAVES)+0:0]           pend_raddr,
    input  logic signed [DW-1:0]                pend_rdata
);

    localparam int LOG   = $clog2(LEAVES);
    localparam int SPAN  = 1 << LOG;
    localparam int NODES = 2 * SPAN - 1;
    localparam int AW    = LOG + 1;
    localparam int PW    = LOG + 1;
    localparam int LW    = $clog2(LOG + 1);
    localparam int RW    = $clog2(LEAVES + 1);

    walk_state_t state_reg, state_next;
    logic [AW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic                   done_reg, done_next;
    logic signed [DW-1:0]   result_reg, result_next;

    logic                   op_reg, op_next;
    logic [PW-1:0]          qa_reg, qa_next;
    logic [PW-1:0]          qb_reg, qb_next;
    logic signed [DW-1:0]   x_reg, x_next;
    logic [AW-1:0]          k_reg, k_next;
    logic [LW-1:0]          lev_reg, lev_next;
    logic [PW-1:0]          lo_reg, lo_next;
    logic [PW-1:0]          size_reg, size_next;
    logic signed [DW-1:0]   m1_reg, m1_next;
    logic signed [DW-1:0]   p_reg, p_next;
    logic signed [DW-1:0]   t_reg, t_next;
    logic                   disj_reg, disj_next;
    logic                   full_reg, full_next;
    logic                   child_sel_reg, child_sel_next;
    logic signed [DW-1:0]   ret_val_reg, ret_val_next;
    logic                   ret_ok_reg, ret_ok_next;

    logic                   stk_phase_reg [LOG+1];
    logic signed [DW-1:0]   stk_val_reg   [LOG+1];
    logic                   stk_ok_reg    [LOG+1];
    logic                   stk_we;
    logic [LW-1:0]          stk_widx;
    logic                   stk_phase_w;
    logic signed [DW-1:0]   stk_val_w;
    logic                   stk_ok_w;

    logic [PW-1:0]          a_cl, b_cl, node_hi;
    logic [AW-1:0]          child_l, child_r, parent;
    logic [LW-1:0]          pl;
    logic                   is_add, leaf, disj_c, full_c, need_child;
    logic                   l_ok, c_ok;
    logic signed [DW-1:0]   l_val, c_val, nv;

    assign a_cl = (range_low  > RW'(LEAVES)) ? PW'(LEAVES) : PW'(range_low);
    assign b_cl = (range_high > RW'(LEAVES)) ? PW'(LEAVES) : PW'(range_high);

    assign is_add     = (op_reg == OP_ADD);
    assign leaf       = (size_reg == PW'(1));
    assign node_hi    = lo_reg + size_reg;
    assign disj_c     = (qb_reg <= lo_reg) || (node_hi <= qa_reg);
    assign full_c     = (qa_reg <= lo_reg) && (node_hi <= qb_reg);
    assign need_child = !leaf && ((pend_rdata != '0) || (full_c && is_add));

    assign child_l = {k_reg[AW-2:0], 1'b1};
    assign child_r = child_l + AW'(1);
    assign parent  = {1'b0, k_reg[AW-1:1]} - AW'(1);
    assign pl      = lev_reg - LW'(1);

    assign l_val = stk_val_reg[pl];
    assign l_ok  = stk_ok_reg[pl];
    assign nv    = (full_reg && is_add) ? sat_add(m1_reg, x_reg) : m1_reg;

    always_comb
    begin
        if (is_add || (l_ok && ret_ok_reg))
            c_val = (l_val > ret_val_reg) ? l_val : ret_val_reg;
        else if (l_ok)
            c_val = l_val;
        else
            c_val = ret_val_reg;
        c_ok = l_ok || ret_ok_reg;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign range_max = result_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(NODES - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start && (a_cl < b_cl))
                    state_next = ST_READ;
            end
            ST_READ:
                state_next = ST_EVAL;
            ST_EVAL:
                state_next = need_child ? ST_CHILD_A : ST_NODE;
            ST_CHILD_A:
                state_next = ST_CHILD_B;
            ST_CHILD_B:
                state_next = child_sel_reg ? ST_NODE : ST_CHILD_A;
            ST_NODE:
                state_next = (disj_reg || full_reg) ? ST_UP : ST_READ;
            ST_UP:
            begin
                if (lev_reg == '0)
                    state_next = ST_IDLE;
                else if (!stk_phase_reg[pl])
                    state_next = ST_READ;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        op_next        = op_reg;
        qa_next        = qa_reg;
        qb_next        = qb_reg;
        x_next         = x_reg;
        k_next         = k_reg;
        lev_next       = lev_reg;
        lo_next        = lo_reg;
        size_next      = size_reg;
        m1_next        = m1_reg;
        p_next         = p_reg;
        t_next         = t_reg;
        disj_next      = disj_reg;
        full_next      = full_reg;
        child_sel_next = child_sel_reg;
        ret_val_next   = ret_val_reg;
        ret_ok_next    = ret_ok_reg;

        max_we     = 1'b0;
        max_waddr  = k_reg;
        max_wdata  = '0;
        max_raddr  = k_reg;
        pend_we    = 1'b0;
        pend_waddr = k_reg;
        pend_wdata = '0;
        pend_raddr = k_reg;

        stk_we      = 1'b0;
        stk_widx    = lev_reg;
        stk_phase_w = 1'b0;
        stk_val_w   = ret_val_reg;
        stk_ok_w    = ret_ok_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                max_we       = 1'b1;
                max_waddr    = clr_cnt_reg;
                pend_we      = 1'b1;
                pend_waddr   = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next   = opcode;
                    qa_next   = a_cl;
                    qb_next   = b_cl;
                    x_next    = {{(DW-DELTA_W){delta[DELTA_W-1]}}, delta};
                    k_next    = '0;
                    lev_next  = '0;
                    lo_next   = '0;
                    size_next = PW'(SPAN);
                    if (!(a_cl < b_cl))
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                    end
                end
            end
            ST_READ:
            begin
            end
            ST_EVAL:
            begin
                m1_next        = sat_add(max_rdata, pend_rdata);
                p_next         = pend_rdata;
                disj_next      = disj_c;
                full_next      = full_c;
                child_sel_next = 1'b0;
                pend_raddr     = child_l;
            end
            ST_CHILD_A:
                t_next = sat_add(pend_rdata, p_reg);
            ST_CHILD_B:
            begin
                pend_we    = 1'b1;
                pend_waddr = child_sel_reg ? child_r : child_l;
                pend_wdata = (full_reg && is_add) ? sat_add(t_reg, x_reg) : t_reg;
                if (!child_sel_reg)
                begin
                    pend_raddr     = child_r;
                    child_sel_next = 1'b1;
                end
            end
            ST_NODE:
            begin
                max_we       = 1'b1;
                max_wdata    = nv;
                pend_we      = 1'b1;
                ret_val_next = nv;
                ret_ok_next  = !disj_reg;
                if (!disj_reg && !full_reg)
                begin
                    stk_we      = 1'b1;
                    stk_phase_w = 1'b0;
                    k_next      = child_l;
                    lev_next    = lev_reg + LW'(1);
                    size_next   = size_reg >> 1;
                end
            end
            ST_UP:
            begin
                if (lev_reg == '0)
                begin
                    done_next   = 1'b1;
                    result_next = (!is_add && ret_ok_reg) ? ret_val_reg : '0;
                end
                else if (!stk_phase_reg[pl])
                begin
                    stk_we      = 1'b1;
                    stk_widx    = pl;
                    stk_phase_w = 1'b1;
                    k_next      = k_reg + AW'(1);
                    lo_next     = lo_reg + size_reg;
                end
                else
                begin
                    if (is_add)
                    begin
                        max_we    = 1'b1;
                        max_waddr = parent;
                        max_wdata = c_val;
                    end
                    ret_val_next = c_val;
                    ret_ok_next  = c_ok;
                    k_next       = parent;
                    lev_next     = pl;
                    lo_next      = lo_reg - size_reg;
                    size_next    = size_reg << 1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg    <= result_next;
        op_reg        <= op_next;
        qa_reg        <= qa_next;
        qb_reg        <= qb_next;
        x_reg         <= x_next;
        k_reg         <= k_next;
        lev_reg       <= lev_next;
        lo_reg        <= lo_next;
        size_reg      <= size_next;
        m1_reg        <= m1_next;
        p_reg         <= p_next;
        t_reg         <= t_next;
        disj_reg      <= disj_next;
        full_reg      <= full_next;
        child_sel_reg <= child_sel_next;
        ret_val_reg   <= ret_val_next;
        ret_ok_reg    <= ret_ok_next;
        if (stk_we)
        begin
            stk_phase_reg[stk_widx] <= stk_phase_w;
            if (stk_phase_w)
            begin
                stk_val_reg[stk_widx] <= stk_val_w;
                stk_ok_reg[stk_widx]  <= stk_ok_w;
            end
        end
    end

endmodule

### test/lazy_range_add_max_tree_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lazy_range_add_max_tree_unit_tb
// Drives range-add and range-max transactions with random gaps. A shadow lazy
// tree in the scoreboard predicts each maximum, and every done strobe is
// checked in order against it.
// ----------------------------------------------------------------------------
module lazy_range_add_max_tree_unit_tb;
    import lramt_pkg::*;

    localparam int NLEAF   = 1024;
    localparam int IW      = $clog2(NLEAF + 1);
    localparam int SPAN    = 1024;
    localparam int LIMIT   = 3000000;
    localparam int N_RAND  = 1500;

    class tree_scoreboard;
        logic signed [DW-1:0] tmax [2*SPAN];
        logic signed [DW-1:0] tpend [2*SPAN];
        logic signed [DW-1:0] expected_max [$];
        int errors;

        function new();
            for (int i = 0; i < 2*SPAN; i++)
            begin
                tmax[i] = '0;
                tpend[i] = '0;
            end
            errors = 0;
        endfunction

        function logic signed [DW-1:0] sat(logic signed [DW-1:0] a, logic signed [DW-1:0] b);
            logic signed [DW:0] s;
            s = $signed({a[DW-1], a}) + $signed({b[DW-1], b});
            if (s > $signed({1'b0, VAL_MAX}))
                return VAL_MAX;
            if (s < $signed({1'b1, VAL_MIN}))
                return VAL_MIN;
            return s[DW-1:0];
        endfunction

        function void settle(int k, int l, int r);
            if (tpend[k] == 0)
                return;
            tmax[k] = sat(tmax[k], tpend[k]);
            if (r - l > 1)
            begin
                tpend[2*k+1] = sat(tpend[2*k+1], tpend[k]);
                tpend[2*k+2] = sat(tpend[2*k+2], tpend[k]);
            end
            tpend[k] = '0;
        endfunction

        function void add_range(int a, int b, logic signed [DW-1:0] x, int k, int l, int r);
            int m;
            settle(k, l, r);
            if (b <= l || r <= a)
                return;
            if (a <= l && r <= b)
            begin
                tpend[k] = sat(tpend[k], x);
                settle(k, l, r);
                return;
            end
            m = l + (r - l) / 2;
            add_range(a, b, x, 2*k+1, l, m);
            add_range(a, b, x, 2*k+2, m, r);
            tmax[k] = (tmax[2*k+1] > tmax[2*k+2]) ? tmax[2*k+1] : tmax[2*k+2];
        endfunction

        function bit max_range(int a, int b, int k, int l, int r, output logic signed [DW-1:0] v);
            int m;
            bit hl, hr;
            logic signed [DW-1:0] lv, rv;
            v = '0;
            settle(k, l, r);
            if (b <= l || r <= a)
                return 0;
            if (a <= l && r <= b)
            begin
                v = tmax[k];
                return 1;
            end
            m = l + (r - l) / 2;
            hl = max_range(a, b, 2*k+1, l, m, lv);
            hr = max_range(a, b, 2*k+2, m, r, rv);
            if (hl && hr)
                v = (lv > rv) ? lv : rv;
            else if (hl)
                v = lv;
            else if (hr)
                v = rv;
            return hl || hr;
        endfunction

        function void note_input(logic op, logic [IW-1:0] lo_in, logic [IW-1:0] hi_in,
                                 logic signed [DELTA_W-1:0] d);
            int lo, hi;
            logic signed [DW-1:0] v;
            lo = (lo_in > NLEAF) ? NLEAF : lo_in;
            hi = (hi_in > NLEAF) ? NLEAF : hi_in;
            v = '0;
            if (lo < hi)
            begin
                if (op == OP_ADD)
                    add_range(lo, hi, DW'(d), 0, 0, SPAN);
                else if (!max_range(lo, hi, 0, 0, SPAN, v))
                    v = '0;
            end
            if (op == OP_ADD)
                v = '0;
            expected_max = {expected_max, v};
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic signed [DW-1:0] got);
            logic signed [DW-1:0] want;
            if (expected_max.size() == 0)
            begin
                report($sformatf("unexpected result %0d", got));
                return;
            end
            want = expected_max.pop_front();
            if (got !== want)
                report($sformatf("range_max got %0d want %0d", got, want));
        endtask
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      opcode = OP_ADD;
    logic [IW-1:0]             range_low = '0;
    logic [IW-1:0]             range_high = '0;
    logic signed [DELTA_W-1:0] delta = '0;
    logic                      done;
    logic signed [DW-1:0]      range_max;

    tree_scoreboard sb = new();
    int cycles = 0;

    lazy_range_add_max_tree_unit #(.LEAVES(NLEAF)) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .range_low  (range_low),
        .range_high (range_high),
        .delta      (delta),
        .done       (done),
        .range_max  (range_max)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && done)
            sb.check_result(range_max);

    task send(logic op, int lo, int hi, logic signed [DELTA_W-1:0] d);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        opcode = op;
        range_low = IW'(lo);
        range_high = IW'(hi);
        delta = d;
        start = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        sb.note_input(op, IW'(lo), IW'(hi), d);
    endtask

    task send_random();
        int a, b, w;
        logic op;
        logic signed [DELTA_W-1:0] d;
        op = 1'($urandom_range(0, 1));
        d = DELTA_W'($urandom);
        case ($urandom_range(0, 9))
            0:
            begin
                a = $urandom_range(0, 2047);
                b = $urandom_range(0, 2047);
            end
            1:
            begin
                a = $urandom_range(0, NLEAF);
                b = $urandom_range(0, NLEAF);
            end
            default:
            begin
                w = $urandom_range(1, 64);
                a = $urandom_range(0, NLEAF - 1);
                b = a + w;
                if (b > NLEAF)
                    b = NLEAF;
            end
        endcase
        send(op, a, b, d);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send(OP_QUERY, 0, NLEAF, 0);
        send(OP_ADD, 0, NLEAF, 16'sh7fff);
        send(OP_QUERY, 0, NLEAF, 16'sh8000);
        send(OP_ADD, 0, 1, 16'sh8000);
        send(OP_QUERY, 0, 1, 0);
        send(OP_ADD, NLEAF - 1, NLEAF, 16'sh7fff);
        send(OP_QUERY, NLEAF - 1, NLEAF, 0);
        send(OP_QUERY, 500, 600, 16'shffff);
        send(OP_ADD, 600, 500, 16'sh1234);
        send(OP_QUERY, 600, 500, 0);
        send(OP_ADD, 300, 300, 16'sh7fff);
        send(OP_QUERY, 300, 300, 0);
        send(OP_ADD, 1000, 2047, 16'sh0100);
        send(OP_QUERY, 2047, 2047, 0);
        send(OP_QUERY, 1020, 2047, 0);
        send(OP_ADD, NLEAF, NLEAF, 16'sh7fff);
        send(OP_ADD, 0, NLEAF, 16'sh8000);
        send(OP_ADD, 0, NLEAF, 16'sh8000);
        send(OP_QUERY, 0, NLEAF, 0);
        send(OP_QUERY, 1, 1023, 0);
        send(OP_ADD, 1024, 2047, 16'sh5555);
        send(OP_QUERY, 0, 2047, 0);

        for (int i = 0; i < N_RAND; i++)
        begin
            if (i == N_RAND / 2)
            begin
                @(negedge clk);
                start = 1'b0;
                while (sb.expected_max.size() != 0)
                    @(posedge clk);
            end
            send_random();
        end
        @(negedge clk);
        start = 1'b0;

        while (sb.expected_max.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
